// ===== rtl/core/gclt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gclt_pkg;

    // fraction digits kept after the dot
    localparam int MAX_FRACTION_DIGITS = 4;
    localparam logic [2:0] DEXP_LIMIT = 3'(MAX_FRACTION_DIGITS + 1);

    // letter codes
    localparam logic [3:0] NO_LETTER   = 4'd12;
    localparam logic [3:0] STAR_LETTER = 4'd11;

    // result kinds
    localparam logic [1:0] KIND_PARAM = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // special bytes
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CASE_FOLD_MASK = 8'hDF;

    typedef enum logic [1:0] {
        MODE_LETTER  = 2'd0,
        MODE_NUMBER  = 2'd1,
        MODE_SEMI    = 2'd2,
        MODE_BRACKET = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        TOK_CHAR, TOK_DIGIT, TOK_SPACE, TOK_EOL, TOK_SIGN,
        TOK_DOT, TOK_SEMI, TOK_OPEN, TOK_CLOSE, TOK_BAD
    } t_tok;

    // tokenizer state carried between bytes
    typedef struct packed {
        t_mode       mode;
        logic [3:0]  cur_letter;
        logic [31:0] digit_acc;
        logic [2:0]  dot_exp;
        logic        minus_seen;
        logic [11:0] letters_seen;
        logic [7:0]  xor_sum;
    } t_state;

    // one result word
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  letter_code;
        logic [31:0] mantissa;
        logic [2:0]  exponent;
        logic        negative;
        logic [11:0] seen_mask;
        logic [7:0]  line_checksum;
        logic        last;
    } t_result;

    // byte class of an uppercase-folded byte
    function automatic t_tok classify(input logic [7:0] c);
        t_tok t;
        case (c) inside
            ["A":"Z"], CH_STAR: t = TOK_CHAR;
            ["0":"9"]:          t = TOK_DIGIT;
            CH_SPACE, CH_TAB:   t = TOK_SPACE;
            CH_CR, CH_LF:       t = TOK_EOL;
            CH_MINUS:           t = TOK_SIGN;
            CH_DOT:             t = TOK_DOT;
            CH_SEMI:            t = TOK_SEMI;
            CH_OPEN:            t = TOK_OPEN;
            CH_CLOSE:           t = TOK_CLOSE;
            default:            t = TOK_BAD;
        endcase
        return t;
    endfunction

    // parameter letter to code, no letter when unknown
    function automatic logic [3:0] letter_of(input logic [7:0] c);
        logic [3:0] code;
        case (c)
            "G":     code = 4'd0;
            "M":     code = 4'd1;
            "X":     code = 4'd2;
            "Y":     code = 4'd3;
            "Z":     code = 4'd4;
            "E":     code = 4'd5;
            "F":     code = 4'd6;
            "S":     code = 4'd7;
            "P":     code = 4'd8;
            "T":     code = 4'd9;
            "N":     code = 4'd10;
            CH_STAR: code = STAR_LETTER;
            default: code = NO_LETTER;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gclt_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gclt_step (
    input  wire  logic [7:0]       i_char,
    input  wire  gclt_pkg::t_state i_state,
    output       gclt_pkg::t_state o_state,
    output       gclt_pkg::t_result o_res0,
    output       gclt_pkg::t_result o_res1,
    output       logic [1:0]       o_count
);

    logic [7:0]        c;
    gclt_pkg::t_tok    tok;
    logic [3:0]        code;
    logic              emit;
    gclt_pkg::t_result first;
    gclt_pkg::t_result err_res;
    gclt_pkg::t_result end_res;
    logic              ended;
    gclt_pkg::t_state  nxt;

    always_comb begin
        // fold lowercase and classify
        c = i_char;
        if (i_char inside {["a":"z"]}) begin
            c = i_char & gclt_pkg::CASE_FOLD_MASK;
        end
        tok  = gclt_pkg::classify(c);
        code = gclt_pkg::letter_of(c);

        nxt   = i_state;
        emit  = 1'b0;
        ended = 1'b0;

        err_res             = '0;
        err_res.kind        = gclt_pkg::KIND_ERROR;
        err_res.letter_code = gclt_pkg::NO_LETTER;
        first               = err_res;

        // mode handling
        case (i_state.mode)
            gclt_pkg::MODE_NUMBER: begin
                case (tok)
                    gclt_pkg::TOK_DIGIT: begin
                        if (i_state.dot_exp < gclt_pkg::DEXP_LIMIT) begin
                            nxt.digit_acc = (i_state.digit_acc << 3)
                                          + (i_state.digit_acc << 1)
                                          + {28'd0, c[3:0]};
                            if (i_state.dot_exp != 3'd0) begin
                                nxt.dot_exp = i_state.dot_exp + 3'd1;
                            end
                        end
                    end
                    gclt_pkg::TOK_SIGN: begin
                        nxt.minus_seen = 1'b1;
                        nxt.dot_exp    = 3'd0;
                        nxt.digit_acc  = '0;
                    end
                    gclt_pkg::TOK_DOT: begin
                        if (i_state.dot_exp == 3'd0) begin
                            nxt.dot_exp = 3'd1;
                        end
                    end
                    gclt_pkg::TOK_SPACE, gclt_pkg::TOK_EOL: begin
                        emit                = 1'b1;
                        first               = '0;
                        first.kind          = gclt_pkg::KIND_PARAM;
                        first.letter_code   = i_state.cur_letter;
                        first.mantissa      = i_state.digit_acc;
                        first.exponent      = i_state.dot_exp;
                        first.negative      = i_state.minus_seen;
                        nxt.mode            = gclt_pkg::MODE_LETTER;
                        nxt.cur_letter      = gclt_pkg::NO_LETTER;
                    end
                    default: begin
                        emit = 1'b1;
                    end
                endcase
                ended = (tok == gclt_pkg::TOK_EOL);
            end
            gclt_pkg::MODE_LETTER: begin
                case (tok)
                    gclt_pkg::TOK_SEMI:  nxt.mode = gclt_pkg::MODE_SEMI;
                    gclt_pkg::TOK_OPEN:  nxt.mode = gclt_pkg::MODE_BRACKET;
                    gclt_pkg::TOK_SPACE: ;
                    gclt_pkg::TOK_CHAR: begin
                        nxt.cur_letter = code;
                        if (code == gclt_pkg::NO_LETTER) begin
                            emit = 1'b1;
                        end else begin
                            nxt.mode         = gclt_pkg::MODE_NUMBER;
                            nxt.digit_acc    = '0;
                            nxt.dot_exp      = 3'd0;
                            nxt.minus_seen   = 1'b0;
                            nxt.letters_seen = i_state.letters_seen | (12'd1 << code);
                        end
                    end
                    gclt_pkg::TOK_EOL: ended = 1'b1;
                    default:           emit  = 1'b1;
                endcase
            end
            gclt_pkg::MODE_SEMI: begin
                if (tok == gclt_pkg::TOK_EOL) begin
                    nxt.mode = gclt_pkg::MODE_LETTER;
                    ended    = 1'b1;
                end
            end
            default: begin
                if (tok == gclt_pkg::TOK_CLOSE) begin
                    nxt.mode = gclt_pkg::MODE_LETTER;
                end
            end
        endcase

        // end of command word
        end_res               = '0;
        end_res.kind          = gclt_pkg::KIND_END;
        end_res.letter_code   = gclt_pkg::NO_LETTER;
        end_res.seen_mask     = nxt.letters_seen;
        end_res.line_checksum = i_state.xor_sum;
        end_res.last          = 1'b1;

        // checksum and mask update
        if (ended) begin
            nxt.letters_seen = '0;
            nxt.xor_sum      = '0;
        end else if (nxt.cur_letter != gclt_pkg::STAR_LETTER) begin
            nxt.xor_sum = i_state.xor_sum ^ i_char;
        end

        // pack results in order
        o_res1 = end_res;
        if (emit) begin
            o_res0      = first;
            o_res0.last = !ended;
            o_count     = ended ? 2'd2 : 2'd1;
        end else begin
            o_res0  = end_res;
            o_count = ended ? 2'd1 : 2'd0;
        end
        o_state = nxt;
    end

endmodule

`default_nettype wire

// ===== rtl/core/gclt_rbuf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gclt_rbuf (
    input  wire  logic              i_clk,
    input  wire  logic              i_rst_n,
    input  wire  logic              i_load,
    input  wire  gclt_pkg::t_result i_res0,
    input  wire  gclt_pkg::t_result i_res1,
    input  wire  logic [1:0]        i_count,
    input  wire  logic              i_stall,
    output       logic              o_free,
    output       logic              o_valid,
    output       gclt_pkg::t_result o_res
);

    gclt_pkg::t_result r_res [2];
    logic [1:0]        r_cnt;
    logic              r_idx;
    logic              take;
    logic              at_end;

    assign o_valid = (r_cnt != 2'd0);
    assign take    = o_valid && !i_stall;
    assign at_end  = ({1'b0, r_idx} + 2'd1 == r_cnt);
    assign o_free  = (r_cnt == 2'd0) || (take && at_end);
    assign o_res   = r_res[r_idx];

    // word count and read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_idx <= 1'b0;
        end else if (i_load) begin
            r_cnt <= i_count;
            r_idx <= 1'b0;
        end else if (take) begin
            if (at_end) begin
                r_cnt <= 2'd0;
            end else begin
                r_idx <= 1'b1;
            end
        end
    end

    // result words
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res[0] <= i_res0;
            r_res[1] <= i_res1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/gcode_line_tokenizer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// each accepted byte is registered at the input, and its result words in the result buffer
// throughput: one byte per cycle while the receiver does not stall; a byte giving two
// words (line end inside a number) holds the input while the result buffer drains
// reset: synchronous active low, clears mode, letter, accumulators, mask,
// checksum and all valid flags

module gcode_line_tokenizer_top (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic        i_valid,
    output       logic        o_stall,
    input  wire  logic [7:0]  i_char_in,
    output       logic        o_valid,
    input  wire  logic        i_stall,
    output       logic [1:0]  o_kind,
    output       logic [3:0]  o_letter_code,
    output       logic [31:0] o_mantissa,
    output       logic [2:0]  o_exponent,
    output       logic        o_negative,
    output       logic [11:0] o_seen_mask,
    output       logic [7:0]  o_line_checksum,
    output       logic        o_last
);

    logic              r_in_valid;
    logic [7:0]        r_in_char;
    gclt_pkg::t_state  r_state;
    gclt_pkg::t_state  n_state;
    gclt_pkg::t_result res0;
    gclt_pkg::t_result res1;
    gclt_pkg::t_result out_res;
    logic [1:0]        count;
    logic              buf_free;
    logic              consume;

    assign consume = r_in_valid && buf_free;
    assign o_stall = r_in_valid && !buf_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_char <= i_char_in;
        end
    end

    // tokenizer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode:         gclt_pkg::MODE_LETTER,
                         cur_letter:   gclt_pkg::NO_LETTER,
                         digit_acc:    32'd0,
                         dot_exp:      3'd0,
                         minus_seen:   1'b0,
                         letters_seen: 12'd0,
                         xor_sum:      8'd0};
        end else if (consume) begin
            r_state <= n_state;
        end
    end

    gclt_step u_step (
        .i_char  (r_in_char),
        .i_state (r_state),
        .o_state (n_state),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_count (count)
    );

    gclt_rbuf u_rbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (consume),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_count (count),
        .i_stall (i_stall),
        .o_free  (buf_free),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    // output fields
    assign o_kind          = out_res.kind;
    assign o_letter_code   = out_res.letter_code;
    assign o_mantissa      = out_res.mantissa;
    assign o_exponent      = out_res.exponent;
    assign o_negative      = out_res.negative;
    assign o_seen_mask     = out_res.seen_mask;
    assign o_line_checksum = out_res.line_checksum;
    assign o_last          = out_res.last;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import gclt_pkg::*;

    // letter code of X, used in the directed rows
    localparam logic [3:0] CODE_X = 4'd2;
    localparam int RANDOM_BYTES   = 1400;
    localparam int QUIET_FROM     = 600;
    localparam int QUIET_TO       = 900;
    localparam int PAUSE_AT       = 1100;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_char_in = 8'h00;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [3:0]  o_letter_code;
    logic [31:0] o_mantissa;
    logic [2:0]  o_exponent;
    logic        o_negative;
    logic [11:0] o_seen_mask;
    logic [7:0]  o_line_checksum;
    logic        o_last;

    gcode_line_tokenizer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_char_in       (i_char_in),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_letter_code   (o_letter_code),
        .o_mantissa      (o_mantissa),
        .o_exponent      (o_exponent),
        .o_negative      (o_negative),
        .o_seen_mask     (o_seen_mask),
        .o_line_checksum (o_line_checksum),
        .o_last          (o_last)
    );

    // clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // parameter letters in code order
    logic [7:0] letter_table [12] = '{"G", "M", "X", "Y", "Z", "E", "F", "S", "P", "T", "N",
                                      CH_STAR};

    // tokenizer state mirrored by the testbench
    t_mode       tk_mode = MODE_LETTER;
    logic [3:0]  tk_letter = NO_LETTER;
    logic [31:0] tk_acc = '0;
    logic [2:0]  tk_dexp = '0;
    logic        tk_minus = 1'b0;
    logic [11:0] tk_mask = '0;
    logic [7:0]  tk_sum = '0;

    // result words still to come, oldest first
    t_result expected_words [$];

    typedef struct {
        logic [7:0] ch;
        bit         typed;
        t_result    word;
    } t_row;
    t_row directed_rows [$];

    int      error_count = 0;
    int      sent_count = 0;
    int      words_checked = 0;
    int      ends_seen = 0;
    int      errors_seen = 0;
    logic    quiet_stretch = 1'b0;
    t_result want;

    function automatic t_result make_word(logic [1:0] kind, logic [3:0] code,
                                          logic [31:0] mant, logic [2:0] expo, logic neg,
                                          logic [11:0] mask, logic [7:0] sum, logic fin);
        t_result w;
        w.kind          = kind;
        w.letter_code   = code;
        w.mantissa      = mant;
        w.exponent      = expo;
        w.negative      = neg;
        w.seen_mask     = mask;
        w.line_checksum = sum;
        w.last          = fin;
        return w;
    endfunction

    // advance the mirrored tokenizer by one byte and queue the words it gives
    task automatic tokenize_byte(input logic [7:0] raw);
        logic [7:0] c;
        t_tok       tok;
        logic       ended;
        int         n_words;
        t_result    err_word;
        c        = raw;
        ended    = 1'b0;
        n_words  = 0;
        err_word = make_word(KIND_ERROR, NO_LETTER, '0, '0, 1'b0, '0, '0, 1'b0);
        if (c >= "a" && c <= "z") c = c & CASE_FOLD_MASK;

        // byte class, first match wins
        if ((c >= "A" && c <= "Z") || c == CH_STAR) tok = TOK_CHAR;
        else if (c >= "0" && c <= "9") tok = TOK_DIGIT;
        else if (c == CH_SPACE || c == CH_TAB) tok = TOK_SPACE;
        else if (c == CH_CR || c == CH_LF) tok = TOK_EOL;
        else if (c == CH_MINUS) tok = TOK_SIGN;
        else if (c == CH_DOT) tok = TOK_DOT;
        else if (c == CH_SEMI) tok = TOK_SEMI;
        else if (c == CH_OPEN) tok = TOK_OPEN;
        else if (c == CH_CLOSE) tok = TOK_CLOSE;
        else tok = TOK_BAD;

        case (tk_mode)
            MODE_NUMBER: begin
                case (tok)
                    TOK_DIGIT: begin
                        // digits past the fraction limit are dropped
                        if (tk_dexp < DEXP_LIMIT) begin
                            tk_acc = tk_acc * 32'd10 + {28'd0, c[3:0]};
                            if (tk_dexp != 3'd0) tk_dexp = tk_dexp + 3'd1;
                        end
                    end
                    TOK_SIGN: begin
                        tk_minus = 1'b1;
                        tk_dexp  = '0;
                        tk_acc   = '0;
                    end
                    TOK_DOT: begin
                        if (tk_dexp == 3'd0) tk_dexp = 3'd1;
                    end
                    TOK_SPACE, TOK_EOL: begin
                        expected_words.push_back(make_word(KIND_PARAM, tk_letter, tk_acc,
                                                           tk_dexp, tk_minus, '0, '0, 1'b0));
                        n_words++;
                        tk_mode   = MODE_LETTER;
                        tk_letter = NO_LETTER;
                    end
                    default: begin
                        expected_words.push_back(err_word);
                        n_words++;
                    end
                endcase
                if (tok == TOK_EOL) ended = 1'b1;
            end
            MODE_LETTER: begin
                case (tok)
                    TOK_SEMI:  tk_mode = MODE_SEMI;
                    TOK_OPEN:  tk_mode = MODE_BRACKET;
                    TOK_SPACE: ;
                    TOK_CHAR: begin
                        tk_letter = NO_LETTER;
                        for (int i = 0; i < 12; i++)
                            if (letter_table[i] == c) tk_letter = 4'(i);
                        if (tk_letter == NO_LETTER) begin
                            expected_words.push_back(err_word);
                            n_words++;
                        end else begin
                            tk_mode  = MODE_NUMBER;
                            tk_acc   = '0;
                            tk_dexp  = '0;
                            tk_minus = 1'b0;
                            tk_mask  = tk_mask | (12'd1 << tk_letter);
                        end
                    end
                    TOK_EOL: ended = 1'b1;
                    default: begin
                        expected_words.push_back(err_word);
                        n_words++;
                    end
                endcase
            end
            MODE_SEMI: begin
                if (tok == TOK_EOL) begin
                    tk_mode = MODE_LETTER;
                    ended   = 1'b1;
                end
            end
            default: begin
                if (tok == TOK_CLOSE) tk_mode = MODE_LETTER;
            end
        endcase

        // end of command, or checksum update outside the star field
        if (ended) begin
            expected_words.push_back(make_word(KIND_END, NO_LETTER, '0, '0, 1'b0, tk_mask,
                                               tk_sum, 1'b0));
            n_words++;
            tk_mask = '0;
            tk_sum  = '0;
        end else if (tk_letter != STAR_LETTER) begin
            tk_sum = tk_sum ^ raw;
        end

        if (n_words > 0) expected_words[expected_words.size() - 1].last = 1'b1;
    endtask

    // offer one byte, with a random gap first, and wait until it is taken
    task automatic send_byte(input logic [7:0] b);
        while (!quiet_stretch && $urandom_range(99) < 18) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_char_in <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tokenize_byte(b);
        sent_count++;
    endtask

    // wait for every queued word to arrive, bounded
    task automatic drain_words(input int max_cycles);
        int waited;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (expected_words.size() != 0 && waited < max_cycles);
    endtask

    function automatic logic [7:0] random_digit();
        return 8'h30 + 8'($urandom_range(9));
    endfunction

    // one parameter: letter, optional sign, digits, optional fraction
    task automatic send_number_word();
        logic [7:0] ch;
        int         n_int;
        ch = letter_table[$urandom_range(11)];
        if (ch != CH_STAR && $urandom_range(1) == 1) ch = ch | 8'h20;
        send_byte(ch);
        if ($urandom_range(3) == 0) send_byte(CH_MINUS);
        n_int = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(4);
        repeat (n_int) send_byte(random_digit());
        if ($urandom_range(2) == 0) begin
            send_byte(CH_DOT);
            repeat ($urandom_range(6)) send_byte(random_digit());
            if ($urandom_range(7) == 0) begin
                send_byte(CH_DOT);
                send_byte(random_digit());
            end
        end
        // sign or junk in the middle of a number
        if ($urandom_range(15) == 0) begin
            send_byte(CH_MINUS);
            send_byte(random_digit());
        end
        if ($urandom_range(19) == 0) send_byte(8'($urandom_range(255)));
    endtask

    // one command line, mostly well formed, sometimes noise
    task automatic send_line();
        int n_params;
        int pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
        end else begin
            n_params = $urandom_range(5);
            for (int i = 0; i < n_params; i++) begin
                send_number_word();
                if (i < n_params - 1 || $urandom_range(1) == 1)
                    send_byte(($urandom_range(3) == 0) ? CH_TAB : CH_SPACE);
            end
            if (pick < 27) begin
                send_byte(CH_SEMI);
                repeat ($urandom_range(6)) send_byte(8'($urandom_range(8'h20, 8'h7E)));
            end else if (pick < 37) begin
                send_byte(CH_OPEN);
                repeat ($urandom_range(5))
                    send_byte(($urandom_range(4) == 0) ? CH_LF : 8'($urandom_range(255)));
                send_byte(CH_CLOSE);
            end
        end
        // line end: LF, CR or CR LF
        pick = $urandom_range(2);
        if (pick != 0) send_byte(CH_CR);
        if (pick != 1) send_byte(CH_LF);
    endtask

    // output check against the oldest expectation
    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected: kind %0d", o_kind);
                error_count++;
            end else begin
                want = expected_words.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_kind));
                check_field("letter_code", 32'(want.letter_code), 32'(o_letter_code));
                check_field("mantissa", want.mantissa, o_mantissa);
                check_field("exponent", 32'(want.exponent), 32'(o_exponent));
                check_field("negative", 32'(want.negative), 32'(o_negative));
                check_field("seen_mask", 32'(want.seen_mask), 32'(o_seen_mask));
                check_field("line_checksum", 32'(want.line_checksum), 32'(o_line_checksum));
                check_field("last", 32'(want.last), 32'(o_last));
                words_checked++;
                if (want.kind == KIND_END) ends_seen++;
                if (want.kind == KIND_ERROR) errors_seen++;
            end
        end
    end

    // receiver stall, off during the quiet stretch
    always @(posedge i_clk) begin
        i_stall <= !quiet_stretch && ($urandom_range(99) < 18);
    end

    function automatic void add_row(logic [7:0] ch, bit typed, t_result word);
        t_row r;
        r.ch    = ch;
        r.typed = typed;
        r.word  = word;
        directed_rows.push_back(r);
    endfunction

    // stimulus
    initial begin
        string   big_digits;
        t_result none;
        bit      paused;
        none       = '0;
        paused     = 1'b0;
        big_digits = "4294967295";

        // unknown letter, then an end carrying its checksum
        add_row("Q", 1'b1, make_word(KIND_ERROR, NO_LETTER, '0, '0, 1'b0, '0, '0, 1'b1));
        add_row(CH_LF, 1'b1, make_word(KIND_END, NO_LETTER, '0, '0, 1'b0, '0, 8'h51, 1'b1));
        // largest mantissa, lowercase letter
        add_row("x", 1'b0, none);
        for (int i = 0; i < big_digits.len(); i++) add_row(big_digits[i], 1'b0, none);
        add_row(CH_SPACE, 1'b1, make_word(KIND_PARAM, CODE_X, 32'hFFFF_FFFF, '0, 1'b0, '0, '0,
                                          1'b1));
        // sign, dot, second dot, CR as line end inside a number, then LF empty end
        add_row("F", 1'b0, none);
        add_row(CH_MINUS, 1'b0, none);
        add_row(CH_DOT, 1'b0, none);
        add_row("5", 1'b0, none);
        add_row(CH_DOT, 1'b0, none);
        add_row(CH_CR, 1'b0, none);
        add_row(CH_LF, 1'b1, make_word(KIND_END, NO_LETTER, '0, '0, 1'b0, '0, '0, 1'b1));
        // semicolon comment swallows a bad byte
        add_row(CH_SEMI, 1'b0, none);
        add_row(8'hFF, 1'b0, none);
        add_row(CH_LF, 1'b1, make_word(KIND_END, NO_LETTER, '0, '0, 1'b0, '0, 8'hC4, 1'b1));
        // line end inside a bracket comment is ignored
        add_row(CH_OPEN, 1'b0, none);
        add_row(CH_CR, 1'b0, none);
        add_row(CH_CLOSE, 1'b0, none);
        // bad bytes in letter mode
        add_row(8'hFF, 1'b1, make_word(KIND_ERROR, NO_LETTER, '0, '0, 1'b0, '0, '0, 1'b1));
        add_row(8'h00, 1'b1, make_word(KIND_ERROR, NO_LETTER, '0, '0, 1'b0, '0, '0, 1'b1));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].ch);
            // typed expectation takes the place of the predicted word
            if (directed_rows[i].typed)
                expected_words[expected_words.size() - 1] = directed_rows[i].word;
        end

        // hold the sender until the directed words are all back
        i_valid <= 1'b0;
        drain_words(DRAIN_LIMIT);

        while (sent_count < directed_rows.size() + RANDOM_BYTES) begin
            quiet_stretch <= (sent_count >= QUIET_FROM && sent_count < QUIET_TO);
            if (!paused && sent_count >= PAUSE_AT) begin
                paused = 1'b1;
                i_valid <= 1'b0;
                drain_words(DRAIN_LIMIT);
            end
            send_line();
        end

        i_valid <= 1'b0;
        drain_words(DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            $error("%0d expected result words never arrived", expected_words.size());
            error_count += expected_words.size();
        end

        $display("tb: %0d bytes sent, %0d result words checked", sent_count, words_checked);
        $display("tb: %0d ends of command, %0d error words", ends_seen, errors_seen);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
